// ===== rtl/jrc_pkg.sv =====
// Shared types and constants for the journal record checker.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package jrc_pkg;

  // Reflected CRC-32 polynomial and the all-ones init/final-xor value.
  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

  // Record magic, first byte in the lowest bits.
  localparam logic [31:0] MAGIC_WORD = 32'h324A_5053;

  // Length of the digest and reference blocks in bytes.
  localparam int BLOCK_BYTES = 16;

  // Verdict codes.
  typedef enum logic [2:0] {
    ERR_OK      = 3'd0,
    ERR_MAGIC   = 3'd1,
    ERR_TRUNC   = 3'd2,
    ERR_NEG_LEN = 3'd3,
    ERR_CRC     = 3'd4,
    ERR_TRAILER = 3'd5
  } err_code_t;

  // One verdict as handed from the parser to the output register.
  typedef struct packed {
    logic               record_ok;
    err_code_t          error_code;
    logic signed [31:0] epoch;
    logic signed [31:0] units_declared;
    logic        [31:0] probe_bits;
    logic        [31:0] stored_crc;
    logic        [31:0] computed_crc;
    logic signed [31:0] trailer_epoch;
  } verdict_t;

  // Expected magic byte at a given position.
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = MAGIC_WORD[7:0];
      2'd1:    b = MAGIC_WORD[15:8];
      2'd2:    b = MAGIC_WORD[23:16];
      default: b = MAGIC_WORD[31:24];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/journal_record_checker.sv =====
// Journal record checker, top level: input stage, parser and verdict register.
// Depends on jrc_pkg and jrc_parser.
//
// Usage:
//   A record enters on the in_ stream one byte per transaction, in_tdata[7:0]
//   holding the byte and in_tlast marking its final byte. Exactly one verdict
//   transaction leaves on the out_ stream for each byte marked by in_tlast;
//   no other byte produces output. The cfg_ channel writes the CRC variant
//   (0 standard CRC-32 with trailer check, 1 zero-init CRC that skips the
//   epoch and count); write it only while no record is in flight.
//   Timing: a byte is registered in the input stage when it is accepted and
//   parsed from there; when a marked byte moves on, its verdict is registered
//   in the verdict register, which drives out_tvalid until the verdict leaves.
//   Throughput: one byte per cycle while no held verdict blocks a marked byte,
//   as the CRC byte update and field counters in the parser are combinational.
//   Reset (rst_n low, synchronous) empties both registers, sets the variant
//   to 0 and starts a new record. When the receiver stalls, the verdict is
//   held and the byte stream keeps flowing until another marked byte would
//   need the output register; then in_tready drops until the verdict leaves.
`default_nettype none

module journal_record_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Byte stream in; tdata: [7:0] data_byte. tlast: last_byte.
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,
  input  wire logic         in_tlast,
  // Verdicts out; tdata: [0] record_ok, [3:1] error_code, [35:4] epoch,
  // [67:36] units_declared, [99:68] probe_bits, [131:100] stored_crc,
  // [163:132] computed_crc, [195:164] trailer_epoch, [199:196] zero.
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [199:0]      out_tdata,
  // Variant register write.
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_data
);

  logic              stage_valid_r;
  logic [7:0]        stage_byte_r;
  logic              stage_last_r;
  logic              out_valid_r;
  jrc_pkg::verdict_t out_data_r;
  jrc_pkg::verdict_t verdict;
  logic              step;

  // The staged byte moves on unless it carries a verdict that has nowhere to go.
  assign step      = stage_valid_r && (!stage_last_r || !out_valid_r || out_tready);
  assign in_tready = !stage_valid_r || step;
  assign cfg_ready = 1'b1;

  jrc_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .data_byte   (stage_byte_r),
    .last_byte   (stage_last_r),
    .cfg_we      (cfg_valid),
    .cfg_variant (cfg_data),
    .verdict     (verdict)
  );

  // Input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_tready) begin
      stage_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      stage_byte_r <= in_tdata;
      stage_last_r <= in_tlast;
    end
  end

  // Verdict register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && stage_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && stage_last_r) begin
      out_data_r <= verdict;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0,
                       out_data_r.trailer_epoch,
                       out_data_r.computed_crc,
                       out_data_r.stored_crc,
                       out_data_r.probe_bits,
                       out_data_r.units_declared,
                       out_data_r.epoch,
                       out_data_r.error_code,
                       out_data_r.record_ok};

  // A held verdict is never overwritten by the next one.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !(step && stage_last_r))
    else $error("verdict overwritten while stalled");

  // The ok flag agrees with the error code.
  a_ok_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[3:1] == jrc_pkg::ERR_OK)))
    else $error("record_ok disagrees with error_code");

  // A passing record always has matching stored and computed CRC.
  a_ok_crc_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> (out_tdata[163:132] == out_tdata[131:100]))
    else $error("passing record with CRC mismatch");

endmodule

`default_nettype wire

// ===== rtl/jrc_crc_byte.sv =====
// One-byte update of a reflected CRC-32, bit by bit over eight steps.
// Depends on jrc_pkg for the polynomial.
`default_nettype none

module jrc_crc_byte (
  input  wire logic [31:0] crc_in,
  input  wire logic [7:0]  data_in,
  output logic      [31:0] crc_out
);

  // Fold the byte in, then shift out eight bits against the polynomial.
  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data_in};
    for (int k = 0; k < 8; k++) begin
      c = {1'b0, c[31:1]} ^ (jrc_pkg::CRC_POLY & {32{c[0]}});
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

// ===== rtl/jrc_parser.sv =====
// Record parser: walks the record layout one byte per step, keeps the CRC
// and the header fields, and forms the verdict on the marked last byte.
// Depends on jrc_pkg and jrc_crc_byte.
`default_nettype none

module jrc_parser (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  input  wire logic              cfg_we,
  input  wire logic              cfg_variant,
  output jrc_pkg::verdict_t      verdict
);

  typedef enum logic [3:0] {
    PH_MAGIC   = 4'd0,
    PH_EPOCH   = 4'd1,
    PH_COUNT   = 4'd2,
    PH_ULEN    = 4'd3,
    PH_UDATA   = 4'd4,
    PH_PROBE   = 4'd5,
    PH_DIGEST  = 4'd6,
    PH_REF     = 4'd7,
    PH_CRC     = 4'd8,
    PH_TRAILER = 4'd9,
    PH_DONE    = 4'd10
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [3:0]          bif_r, bif_nxt;
  logic [31:0]         shift_r, shift_nxt;
  logic [31:0]         crc_r, crc_nxt;
  logic [31:0]         epoch_r, epoch_nxt;
  logic [31:0]         count_r, count_nxt;
  logic [30:0]         units_r, units_nxt;
  logic [30:0]         ubytes_r, ubytes_nxt;
  logic [31:0]         probe_r, probe_nxt;
  logic [31:0]         crc_read_r, crc_read_nxt;
  logic [31:0]         trailer_r, trailer_nxt;
  jrc_pkg::err_code_t  error_r, error_nxt;
  logic                variant_r, variant_nxt;
  logic [31:0]         crc_upd;

  jrc_crc_byte u_crc (
    .crc_in  (crc_r),
    .data_in (data_byte),
    .crc_out (crc_upd)
  );

  // Next state of the record walk and the verdict for the current byte.
  always_comb begin
    logic [31:0]        word;
    logic               covered;
    logic [30:0]        units_dec;
    logic [30:0]        ubytes_dec;
    logic [31:0]        computed;
    jrc_pkg::err_code_t code;

    phase_nxt    = phase_r;
    bif_nxt      = bif_r;
    shift_nxt    = shift_r;
    crc_nxt      = crc_r;
    epoch_nxt    = epoch_r;
    count_nxt    = count_r;
    units_nxt    = units_r;
    ubytes_nxt   = ubytes_r;
    probe_nxt    = probe_r;
    crc_read_nxt = crc_read_r;
    trailer_nxt  = trailer_r;
    error_nxt    = error_r;
    variant_nxt  = variant_r;

    word       = {data_byte, shift_r[31:8]};
    units_dec  = units_r - 31'd1;
    ubytes_dec = ubytes_r - 31'd1;
    covered    = (phase_r >= PH_EPOCH) && (phase_r <= PH_REF) &&
                 !(variant_r && ((phase_r == PH_EPOCH) || (phase_r == PH_COUNT)));

    if (step && (error_r == jrc_pkg::ERR_OK) && (phase_r != PH_DONE)) begin
      if (covered) begin
        crc_nxt = crc_upd;
      end
      case (phase_r)
        PH_MAGIC: begin
          if (data_byte != jrc_pkg::magic_byte(bif_r[1:0])) begin
            error_nxt = jrc_pkg::ERR_MAGIC;
            phase_nxt = PH_DONE;
          end else if (bif_r == 4'd3) begin
            bif_nxt   = 4'd0;
            phase_nxt = PH_EPOCH;
          end else begin
            bif_nxt = bif_r + 4'd1;
          end
        end
        PH_UDATA: begin
          ubytes_nxt = ubytes_dec;
          if (ubytes_dec == 31'd0) begin
            units_nxt = units_dec;
            phase_nxt = (units_dec != 31'd0) ? PH_ULEN : PH_PROBE;
          end
        end
        PH_DIGEST, PH_REF: begin
          if (bif_r == 4'(jrc_pkg::BLOCK_BYTES - 1)) begin
            bif_nxt   = 4'd0;
            phase_nxt = (phase_r == PH_DIGEST) ? PH_REF : PH_CRC;
          end else begin
            bif_nxt = bif_r + 4'd1;
          end
        end
        PH_EPOCH, PH_COUNT, PH_ULEN, PH_PROBE, PH_CRC, PH_TRAILER: begin
          if (bif_r == 4'd3) begin
            // A little-endian word is complete.
            bif_nxt   = 4'd0;
            shift_nxt = 32'd0;
            case (phase_r)
              PH_EPOCH: begin
                epoch_nxt = word;
                phase_nxt = PH_COUNT;
              end
              PH_COUNT: begin
                count_nxt = word;
                units_nxt = word[31] ? 31'd0 : word[30:0];
                phase_nxt = (!word[31] && (word[30:0] != 31'd0)) ? PH_ULEN : PH_PROBE;
              end
              PH_ULEN: begin
                if (word[31]) begin
                  error_nxt = jrc_pkg::ERR_NEG_LEN;
                  phase_nxt = PH_DONE;
                end else if (word[30:0] == 31'd0) begin
                  units_nxt = units_dec;
                  phase_nxt = (units_dec != 31'd0) ? PH_ULEN : PH_PROBE;
                end else begin
                  ubytes_nxt = word[30:0];
                  phase_nxt  = PH_UDATA;
                end
              end
              PH_PROBE: begin
                probe_nxt = word;
                phase_nxt = PH_DIGEST;
              end
              PH_CRC: begin
                crc_read_nxt = word;
                phase_nxt    = PH_TRAILER;
              end
              default: begin
                trailer_nxt = word;
                phase_nxt   = PH_DONE;
              end
            endcase
          end else begin
            bif_nxt   = bif_r + 4'd1;
            shift_nxt = word;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end

    // Verdict from the state as it stands after this byte.
    computed = variant_r ? crc_nxt : (crc_nxt ^ jrc_pkg::CRC_ALL_ONES);
    if (error_nxt != jrc_pkg::ERR_OK) begin
      code = error_nxt;
    end else if (phase_nxt != PH_DONE) begin
      code = jrc_pkg::ERR_TRUNC;
    end else if (computed != crc_read_nxt) begin
      code = jrc_pkg::ERR_CRC;
    end else if (!variant_r && (trailer_nxt != epoch_nxt)) begin
      code = jrc_pkg::ERR_TRAILER;
    end else begin
      code = jrc_pkg::ERR_OK;
    end
    verdict.record_ok      = (code == jrc_pkg::ERR_OK);
    verdict.error_code     = code;
    verdict.epoch          = epoch_nxt;
    verdict.units_declared = count_nxt;
    verdict.probe_bits     = probe_nxt;
    verdict.stored_crc     = crc_read_nxt;
    verdict.computed_crc   = computed;
    verdict.trailer_epoch  = trailer_nxt;

    // Variant write; the CRC init follows it only before a record starts.
    if (cfg_we) begin
      variant_nxt = cfg_variant;
      if ((phase_r == PH_MAGIC) && (bif_r == 4'd0) && (error_r == jrc_pkg::ERR_OK)) begin
        crc_nxt = cfg_variant ? 32'd0 : jrc_pkg::CRC_ALL_ONES;
      end
    end

    // After a verdict the next byte starts a new record.
    if (step && last_byte) begin
      phase_nxt    = PH_MAGIC;
      bif_nxt      = 4'd0;
      shift_nxt    = 32'd0;
      crc_nxt      = variant_r ? 32'd0 : jrc_pkg::CRC_ALL_ONES;
      epoch_nxt    = 32'd0;
      count_nxt    = 32'd0;
      units_nxt    = 31'd0;
      ubytes_nxt   = 31'd0;
      probe_nxt    = 32'd0;
      crc_read_nxt = 32'd0;
      trailer_nxt  = 32'd0;
      error_nxt    = jrc_pkg::ERR_OK;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_MAGIC;
      bif_r      <= 4'd0;
      shift_r    <= 32'd0;
      crc_r      <= jrc_pkg::CRC_ALL_ONES;
      epoch_r    <= 32'd0;
      count_r    <= 32'd0;
      units_r    <= 31'd0;
      ubytes_r   <= 31'd0;
      probe_r    <= 32'd0;
      crc_read_r <= 32'd0;
      trailer_r  <= 32'd0;
      error_r    <= jrc_pkg::ERR_OK;
      variant_r  <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      bif_r      <= bif_nxt;
      shift_r    <= shift_nxt;
      crc_r      <= crc_nxt;
      epoch_r    <= epoch_nxt;
      count_r    <= count_nxt;
      units_r    <= units_nxt;
      ubytes_r   <= ubytes_nxt;
      probe_r    <= probe_nxt;
      crc_read_r <= crc_read_nxt;
      trailer_r  <= trailer_nxt;
      error_r    <= error_nxt;
      variant_r  <= variant_nxt;
    end
  end

endmodule

`default_nettype wire
